FILE: hdl/ttlb_pkg.sv
`timescale 1ns / 1ps

package ttlb_pkg;

  // Default sizes
  localparam int TLB_ENTRIES_DEF       = 8;
  localparam int PROCESS_COUNT_DEF     = 4;
  localparam int PAGES_PER_PROCESS_DEF = 1024;
  localparam int FRAME_BITS_DEF        = 10;

  // Fixed field widths
  localparam int MODE_W  = 2;
  localparam int PID_W   = 2;
  localparam int VA_W    = 22;
  localparam int PNUM_W  = 10;
  localparam int FNUM_W  = 10;
  localparam int STAT_W  = 2;
  localparam int SLOTO_W = 3;
  localparam int OFFB_W  = 4;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [OFFB_W-1:0] MAX_OFFSET_BITS = 4'd12;
  localparam logic [OFFB_W-1:0] OFFSET_BITS_RST = 4'd8;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_MAP       = 2'd1,
    MODE_UNMAP     = 2'd2,
    MODE_UNUSED    = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_HIT   = 2'd0,
    STAT_FILL  = 2'd1,
    STAT_FAULT = 2'd2,
    STAT_DONE  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY = 1'b0,
    CFG_OFFSET = 1'b1
  } cfg_idx_t;

  localparam logic POLICY_LRU = 1'b1;

endpackage

FILE: hdl/ttlb_ram.sv
`timescale 1ns / 1ps

module ttlb_ram #(
  parameter int WIDTH  = 11,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/tagged_tlb_page_translation_unit.sv
`timescale 1ns / 1ps

// The page table read is launched as an item is taken; the result is formed in the
// execute state and registered. No new item is taken while busy is high in that state.
// Reset: the TLB empties at once, then a clearing pass zeroes all PROCESS_COUNT *
// PAGES_PER_PROCESS table entries (4096 by default) with busy high; config writes still land.
// Results are strobed for one cycle only; the receiver cannot stall them.
module tagged_tlb_page_translation_unit import ttlb_pkg::*; #(
  parameter int TLB_ENTRIES       = TLB_ENTRIES_DEF,
  parameter int PROCESS_COUNT     = PROCESS_COUNT_DEF,
  parameter int PAGES_PER_PROCESS = PAGES_PER_PROCESS_DEF,
  parameter int FRAME_BITS        = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [PID_W-1:0]      in_process_id,
  input  logic [VA_W-1:0]       in_virtual_address,
  input  logic [PNUM_W-1:0]     in_page_number,
  input  logic [FNUM_W-1:0]     in_frame_number,
  // result channel
  output logic                  out_valid,
  output logic [STAT_W-1:0]     out_status,
  output logic [VA_W-1:0]       out_physical_address,
  output logic [SLOTO_W-1:0]    out_tlb_slot,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W      = $clog2(TLB_ENTRIES);
  localparam int PAGE_W      = $clog2(PAGES_PER_PROCESS);
  localparam int TABLE_DEPTH = PROCESS_COUNT * PAGES_PER_PROCESS;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TBL_W       = FRAME_BITS + 1;
  localparam int PID_CMP_W   = PID_W + 4;

  localparam logic [VA_W-1:0]      PAGES_LIM = VA_W'(PAGES_PER_PROCESS);
  localparam logic [PID_CMP_W-1:0] PID_LIM   = PID_CMP_W'(PROCESS_COUNT);
  localparam logic [ADDR_W-1:0]    CLR_LAST  = ADDR_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic                  policy_r;
  logic [OFFB_W-1:0]     offset_bits_r;
  logic [OFFB_W-1:0]     ob;

  // TLB entries live in flops so all of them can be matched in parallel
  logic [TLB_ENTRIES-1:0] ent_valid_r;
  logic [PAGE_W-1:0]      ent_page_r  [TLB_ENTRIES];
  logic [FRAME_BITS-1:0]  ent_frame_r [TLB_ENTRIES];
  logic [PID_W-1:0]       ent_owner_r [TLB_ENTRIES];
  logic [CNT_W-1:0]       ent_stamp_r [TLB_ENTRIES];

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]      clr_addr_r;
  logic [SLOT_W-1:0]      victim_r, victim_nxt;

  // request held over the execute cycle
  mode_t                  mode_r;
  logic [PID_W-1:0]       pid_r;
  logic [VA_W-1:0]        page_r;
  logic [VA_W-1:0]        off_r;
  logic [FRAME_BITS-1:0]  fnum_r;

  // result registers
  logic                   out_valid_r;
  logic [STAT_W-1:0]      out_status_r;
  logic [VA_W-1:0]        out_pa_r;
  logic [SLOTO_W-1:0]     out_slot_r;

  // accept side
  logic                   accept;
  logic [VA_W-1:0]        in_page;
  logic [VA_W-1:0]        off_mask;
  logic [ADDR_W-1:0]      rd_addr;

  // page table port
  logic                   tbl_we;
  logic [ADDR_W-1:0]      tbl_waddr;
  logic [TBL_W-1:0]       tbl_wdata;
  logic [TBL_W-1:0]       tbl_rdata;
  logic                   tbl_valid;
  logic [FRAME_BITS-1:0]  tbl_frame;

  // execute side
  logic [TLB_ENTRIES-1:0] hit_vec;
  logic [TLB_ENTRIES-1:0] free_vec;
  logic                   hit_any, free_any;
  logic [SLOT_W-1:0]      hit_idx, free_idx, ins_slot;
  logic                   pid_ok, page_ok;
  logic                   do_lru, do_fill, do_map, do_unmap, do_install;
  logic [FRAME_BITS-1:0]  ins_frame;
  logic [FRAME_BITS-1:0]  pa_frame;
  logic [CNT_W-1:0]       pa_wide;
  logic [STAT_W-1:0]      res_status;
  logic [VA_W-1:0]        res_pa;
  logic [SLOT_W-1:0]      res_slot;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r      <= 1'b0;
      offset_bits_r <= OFFSET_BITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLICY: policy_r      <= cfg_data[0];
        CFG_OFFSET: offset_bits_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Clamp the offset width to the largest page
  assign ob = (offset_bits_r > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_bits_r;

  // ---------------------------------------------------------------------------
  // Accept: split the address and launch the page table read
  // ---------------------------------------------------------------------------
  assign busy     = (state_r != S_IDLE);
  assign accept   = start && (state_r == S_IDLE);
  assign off_mask = ~({VA_W{1'b1}} << ob);
  assign in_page  = (mode_t'(in_mode) == MODE_TRANSLATE) ?
                    (in_virtual_address >> ob) : VA_W'(in_page_number);
  // Out-of-range process or page gives a junk address; the result is a fault then
  assign rd_addr  = ADDR_W'(CNT_W'(in_process_id) * CNT_W'(PAGES_PER_PROCESS)
                            + CNT_W'(in_page));

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_t'(in_mode);
      pid_r  <= in_process_id;
      page_r <= in_page;
      off_r  <= in_virtual_address & off_mask;
      fnum_r <= FRAME_BITS'(in_frame_number);
    end
  end

  ttlb_ram #(
    .WIDTH  (TBL_W),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (tbl_rdata)
  );

  assign tbl_valid = tbl_rdata[TBL_W-1];
  assign tbl_frame = tbl_rdata[FRAME_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Victim by lowest stamp, kept up to date every cycle. Stamps only change in
  // the execute state, and the idle state always lies before the next one.
  // ---------------------------------------------------------------------------
  always_comb begin
    victim_nxt = '0;
    for (int i = 1; i < TLB_ENTRIES; i++) begin
      if (ent_stamp_r[i] < ent_stamp_r[victim_nxt]) begin
        victim_nxt = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    victim_r <= victim_nxt;
  end

  // ---------------------------------------------------------------------------
  // Execute: match, pick a slot, form the result
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_vec[i] = ent_valid_r[i] && (VA_W'(ent_page_r[i]) == page_r)
                   && (ent_owner_r[i] == pid_r);
    end
  end

  // Map drops matching entries first, so those count as free for the install
  assign free_vec = ~ent_valid_r | ((mode_r == MODE_MAP) ? hit_vec : '0);
  assign hit_any  = |hit_vec;
  assign free_any = |free_vec;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (free_vec[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign ins_slot = free_any ? free_idx : victim_r;
  assign pid_ok   = (PID_CMP_W'(pid_r) < PID_LIM);
  assign page_ok  = (page_r < PAGES_LIM);
  assign cnt_nxt  = cnt_r + CNT_W'(1);

  always_comb begin
    do_lru     = 1'b0;
    do_fill    = 1'b0;
    do_map     = 1'b0;
    do_unmap   = 1'b0;
    res_status = STAT_FAULT;
    res_slot   = '0;
    pa_frame   = tbl_frame;
    if (state_r == S_EXEC && pid_ok) begin
      unique case (mode_r)
        MODE_TRANSLATE: begin
          if (hit_any) begin
            do_lru     = (policy_r == POLICY_LRU);
            res_status = STAT_HIT;
            res_slot   = hit_idx;
            pa_frame   = ent_frame_r[hit_idx];
          end else if (page_ok && tbl_valid) begin
            do_fill    = 1'b1;
            res_status = STAT_FILL;
            res_slot   = ins_slot;
          end
        end
        MODE_MAP: begin
          if (page_ok) begin
            do_map     = 1'b1;
            res_status = STAT_DONE;
            res_slot   = ins_slot;
          end
        end
        MODE_UNMAP: begin
          if (page_ok) begin
            do_unmap   = 1'b1;
            res_status = STAT_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  assign do_install = do_fill || do_map;
  assign ins_frame  = do_map ? fnum_r : tbl_frame;
  assign pa_wide    = (CNT_W'(pa_frame) << ob) | CNT_W'(off_r);
  assign res_pa     = (res_status == STAT_HIT || res_status == STAT_FILL) ?
                      VA_W'(pa_wide) : '0;

  // ---------------------------------------------------------------------------
  // Page table writes: clearing pass after reset, then map and unmap
  // ---------------------------------------------------------------------------
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = clr_addr_r;
    tbl_wdata = '0;
    if (state_r == S_CLEAR) begin
      tbl_we = 1'b1;
    end else if (do_map || do_unmap) begin
      tbl_we    = 1'b1;
      tbl_waddr = ADDR_W'(CNT_W'(pid_r) * CNT_W'(PAGES_PER_PROCESS) + CNT_W'(page_r));
      tbl_wdata = do_map ? {1'b1, fnum_r} : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // TLB update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
    end else begin
      if (do_map || do_unmap) begin
        ent_valid_r <= (ent_valid_r & ~hit_vec)
                       | (do_map ? (TLB_ENTRIES'(1) << ins_slot) : '0);
      end else if (do_fill) begin
        ent_valid_r[ins_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_install) begin
      ent_page_r[ins_slot]  <= PAGE_W'(page_r);
      ent_frame_r[ins_slot] <= ins_frame;
      ent_owner_r[ins_slot] <= pid_r;
      ent_stamp_r[ins_slot] <= cnt_nxt;
    end else if (do_lru) begin
      ent_stamp_r[hit_idx]  <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, counter and result registers
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_addr_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EXEC);
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (state_r == S_EXEC) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      out_status_r <= res_status;
      out_pa_r     <= res_pa;
      out_slot_r   <= SLOTO_W'(res_slot);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_physical_address = out_pa_r;
  assign out_tlb_slot         = out_slot_r;

endmodule

FILE: test/tagged_tlb_page_translation_unit_test.sv
`timescale 1ns / 1ps

module tagged_tlb_page_translation_unit_test;
  import ttlb_pkg::*;

  localparam int PT_SIZE     = PROCESS_COUNT_DEF * PAGES_PER_PROCESS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 207;
  localparam int DIRECTED    = 24;

  // One request as driven onto the command ports
  typedef struct packed {
    mode_t       mode;
    logic [1:0]  pid;
    logic [21:0] va;
    logic [9:0]  pnum;
    logic [9:0]  fnum;
  } tlb_request_t;

  // One result as strobed on the result ports
  typedef struct packed {
    status_t     status;
    logic [21:0] pa;
    logic [2:0]  slot;
  } translation_t;

  // Directed row: when typed is set, want is the result read straight off the spec
  typedef struct packed {
    tlb_request_t req;
    bit           typed;
    translation_t want;
  } stim_row_t;

  localparam translation_t FAULTED   = '{STAT_FAULT, 22'h0, 3'd0};
  localparam translation_t DONE_SLOT0 = '{STAT_DONE, 22'h0, 3'd0};

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [1:0]  in_process_id;
  logic [21:0] in_virtual_address;
  logic [9:0]  in_page_number;
  logic [9:0]  in_frame_number;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [21:0] out_physical_address;
  logic [2:0]  out_tlb_slot;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tagged_tlb_page_translation_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_mode              (in_mode),
    .in_process_id        (in_process_id),
    .in_virtual_address   (in_virtual_address),
    .in_page_number       (in_page_number),
    .in_frame_number      (in_frame_number),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_physical_address (out_physical_address),
    .out_tlb_slot         (out_tlb_slot),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the block's state. bit types start at zero, which is the
  // reset state of the TLB, the page tables and the stamp counter.
  // ---------------------------------------------------------------------------
  bit        shadow_policy = 1'b0;
  bit [3:0]  shadow_offset = OFFSET_BITS_RST;
  bit        tlb_valid [TLB_ENTRIES_DEF];
  bit [9:0]  tlb_page  [TLB_ENTRIES_DEF];
  bit [9:0]  tlb_frame [TLB_ENTRIES_DEF];
  bit [1:0]  tlb_owner [TLB_ENTRIES_DEF];
  bit [31:0] tlb_stamp [TLB_ENTRIES_DEF];
  bit        pt_valid  [PT_SIZE];
  bit [9:0]  pt_frame  [PT_SIZE];
  bit [31:0] stamp_clock;

  translation_t pending_translations [$];
  translation_t oldest;
  stim_row_t    directed_rows [DIRECTED];
  int           failures;
  int           items_accepted;
  int           cycle_count;
  int           status_seen [4];
  bit           idle_enable;
  bit [1:0]     recent_pid;
  bit [9:0]     recent_page;
  bit           phase_policy [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  bit [3:0]     phase_offset [PHASES] = '{4'd12, 4'd0, 4'd4, 4'd15, 4'd13, 4'd10, 4'd8};

  // Drop every TLB entry that maps this page of this process
  function automatic void drop_entries(bit [1:0] pid, bit [9:0] page);
    for (int i = 0; i < TLB_ENTRIES_DEF; i++)
      if (tlb_valid[i] && tlb_page[i] == page && tlb_owner[i] == pid)
        tlb_valid[i] = 1'b0;
  endfunction

  // Fill the lowest free slot, else evict the oldest stamp (lowest index on ties)
  function automatic int install_entry(bit [1:0] pid, bit [9:0] page, bit [9:0] frame);
    int slot;
    slot = -1;
    for (int i = TLB_ENTRIES_DEF - 1; i >= 0; i--)
      if (!tlb_valid[i]) slot = i;
    if (slot < 0) begin
      slot = 0;
      for (int i = 1; i < TLB_ENTRIES_DEF; i++)
        if (tlb_stamp[i] < tlb_stamp[slot]) slot = i;
    end
    tlb_valid[slot] = 1'b1;
    tlb_page[slot]  = page;
    tlb_frame[slot] = frame;
    tlb_owner[slot] = pid;
    tlb_stamp[slot] = stamp_clock;
    return slot;
  endfunction

  // Advance the shadow state by one accepted item and return its result
  function automatic translation_t predict_translation(tlb_request_t r);
    translation_t res;
    bit [31:0]    ob;
    bit [31:0]    vpage;
    bit [31:0]    off;
    bit [31:0]    phys;
    bit [9:0]     frame;
    int           hit;
    int           idx;
    res = FAULTED;
    ob = 32'((shadow_offset > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : shadow_offset);
    stamp_clock++;
    if (int'(r.pid) < PROCESS_COUNT_DEF) begin
      case (r.mode)
        MODE_TRANSLATE: begin
          vpage = 32'(r.va) >> ob;
          off   = 32'(r.va) & ((32'd1 << ob) - 32'd1);
          hit   = -1;
          for (int i = TLB_ENTRIES_DEF - 1; i >= 0; i--)
            if (tlb_valid[i] && 32'(tlb_page[i]) == vpage && tlb_owner[i] == r.pid) hit = i;
          if (hit >= 0) begin
            if (shadow_policy == POLICY_LRU) tlb_stamp[hit] = stamp_clock;
            phys       = (32'(tlb_frame[hit]) << ob) | off;
            res.status = STAT_HIT;
            res.slot   = hit[2:0];
            res.pa     = phys[21:0];
          end else if (vpage < PAGES_PER_PROCESS_DEF) begin
            idx = int'(r.pid) * PAGES_PER_PROCESS_DEF + int'(vpage);
            if (pt_valid[idx]) begin
              frame      = pt_frame[idx];
              hit        = install_entry(r.pid, vpage[9:0], frame);
              phys       = (32'(frame) << ob) | off;
              res.status = STAT_FILL;
              res.slot   = hit[2:0];
              res.pa     = phys[21:0];
            end
          end
        end
        MODE_MAP: begin
          if (int'(r.pnum) < PAGES_PER_PROCESS_DEF) begin
            idx           = int'(r.pid) * PAGES_PER_PROCESS_DEF + int'(r.pnum);
            frame         = r.fnum & 10'((1 << FRAME_BITS_DEF) - 1);
            pt_valid[idx] = 1'b1;
            pt_frame[idx] = frame;
            drop_entries(r.pid, r.pnum);
            hit           = install_entry(r.pid, r.pnum, frame);
            res.status    = STAT_DONE;
            res.slot      = hit[2:0];
          end
        end
        MODE_UNMAP: begin
          if (int'(r.pnum) < PAGES_PER_PROCESS_DEF) begin
            idx           = int'(r.pid) * PAGES_PER_PROCESS_DEF + int'(r.pnum);
            pt_valid[idx] = 1'b0;
            pt_frame[idx] = '0;
            drop_entries(r.pid, r.pnum);
            res.status    = STAT_DONE;
          end
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // Mostly well-formed traffic on a small working set so that hits, fills and
  // evictions all happen; the rest is unconstrained noise, unused mode included.
  function automatic tlb_request_t random_request();
    tlb_request_t r;
    int           pick;
    bit [31:0]    ob;
    bit [9:0]     page;
    bit [1:0]     pid;
    ob     = 32'((shadow_offset > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : shadow_offset);
    r.mode = mode_t'($urandom_range(0, 3));
    r.pid  = 2'($urandom_range(0, 3));
    r.va   = 22'($urandom_range(0, 32'h3FFFFF));
    r.pnum = 10'($urandom_range(0, 1023));
    r.fnum = 10'($urandom_range(0, 1023));
    pick   = int'($urandom_range(0, 99));
    if ($urandom_range(0, 2) == 0) begin
      pid  = recent_pid;
      page = recent_page;
    end else begin
      pid  = 2'($urandom_range(0, 3));
      page = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023)) :
                                           10'($urandom_range(0, 9));
    end
    if (pick < 82) begin
      r.pid       = pid;
      r.pnum      = page;
      recent_pid  = pid;
      recent_page = page;
    end
    if (pick < 45) begin
      r.mode = MODE_TRANSLATE;
      r.va   = 22'((32'(page) << ob) | ($urandom() & ((32'd1 << ob) - 32'd1)));
    end else if (pick < 72) begin
      r.mode = MODE_MAP;
    end else if (pick < 82) begin
      r.mode = MODE_UNMAP;
    end
    return r;
  endfunction

  // Write one register; only ever called with no item in flight
  task automatic write_register(cfg_idx_t idx, logic [3:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    if (idx == CFG_POLICY) shadow_policy = value[0];
    else shadow_offset = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Present one item and hold it until the block takes it
  task automatic send_request(tlb_request_t r, bit typed, translation_t want);
    translation_t predicted;
    @(negedge clk);
    start              = 1'b1;
    in_mode            = r.mode;
    in_process_id      = r.pid;
    in_virtual_address = r.va;
    in_page_number     = r.pnum;
    in_frame_number    = r.fnum;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_translation(r);
    pending_translations.push_back(typed ? want : predicted);
    items_accepted++;
  endtask

  // Drop start for a burst of idle cycles, at random
  task automatic maybe_idle();
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tagged_tlb_page_translation_unit test failed");
      $finish;
    end
  end

  // Result checker: every strobe must match the oldest outstanding expected result
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_translations.size() == 0) begin
        $error("unexpected result: status %0d pa %h slot %0d",
               out_status, out_physical_address, out_tlb_slot);
        failures++;
      end else begin
        oldest = pending_translations.pop_front();
        status_seen[out_status]++;
        if (out_status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_status);
          failures++;
        end
        if (out_physical_address !== oldest.pa) begin
          $error("physical_address: expected %h, got %h", oldest.pa, out_physical_address);
          failures++;
        end
        if (out_tlb_slot !== oldest.slot) begin
          $error("tlb_slot: expected %0d, got %0d", oldest.slot, out_tlb_slot);
          failures++;
        end
      end
    end
  end

  initial begin
    // Directed table, run at policy FIFO and 8 offset bits
    directed_rows = '{
      // translate before anything is mapped
      '{'{MODE_TRANSLATE, 2'd0, 22'h000000, 10'd0,    10'h000}, 1'b1, FAULTED},
      '{'{MODE_MAP,       2'd0, 22'h000000, 10'd0,    10'h3FF}, 1'b1, DONE_SLOT0},
      '{'{MODE_TRANSLATE, 2'd0, 22'h0000FF, 10'd0,    10'h000}, 1'b1,
        '{STAT_HIT, 22'h03FFFF, 3'd0}},
      // same page, other process: no match
      '{'{MODE_TRANSLATE, 2'd1, 22'h0000FF, 10'd0,    10'h000}, 1'b1, FAULTED},
      '{'{MODE_MAP,       2'd3, 22'h000000, 10'd1023, 10'h000}, 1'b1,
        '{STAT_DONE, 22'h0, 3'd1}},
      '{'{MODE_TRANSLATE, 2'd3, 22'h03FF80, 10'd0,    10'h000}, 1'b1,
        '{STAT_HIT, 22'h000080, 3'd1}},
      // page number beyond the table
      '{'{MODE_TRANSLATE, 2'd2, 22'h3FFFFF, 10'd0,    10'h000}, 1'b1, FAULTED},
      // unused mode
      '{'{MODE_UNUSED,    2'd3, 22'h3FFFFF, 10'd1023, 10'h3FF}, 1'b1, FAULTED},
      '{'{MODE_UNMAP,     2'd0, 22'h000000, 10'd0,    10'h000}, 1'b1, DONE_SLOT0},
      // unmapped page
      '{'{MODE_TRANSLATE, 2'd0, 22'h000012, 10'd0,    10'h000}, 1'b1, FAULTED},
      '{'{MODE_UNMAP,     2'd2, 22'h000000, 10'd1023, 10'h000}, 1'b1, DONE_SLOT0},
      // remap of the same page, then fill the TLB and force evictions
      '{'{MODE_MAP,       2'd0, 22'h000000, 10'd5,    10'h155}, 1'b0, FAULTED},
      '{'{MODE_MAP,       2'd0, 22'h000000, 10'd5,    10'h2AA}, 1'b0, FAULTED},
      '{'{MODE_MAP,       2'd1, 22'h000000, 10'd1,    10'h011}, 1'b0, FAULTED},
      '{'{MODE_MAP,       2'd1, 22'h000000, 10'd2,    10'h022}, 1'b0, FAULTED},
      '{'{MODE_MAP,       2'd1, 22'h000000, 10'd3,    10'h033}, 1'b0, FAULTED},
      '{'{MODE_MAP,       2'd1, 22'h000000, 10'd4,    10'h044}, 1'b0, FAULTED},
      '{'{MODE_MAP,       2'd1, 22'h000000, 10'd5,    10'h055}, 1'b0, FAULTED},
      '{'{MODE_MAP,       2'd1, 22'h000000, 10'd6,    10'h066}, 1'b0, FAULTED},
      '{'{MODE_MAP,       2'd2, 22'h000000, 10'd9,    10'h200}, 1'b0, FAULTED},
      '{'{MODE_TRANSLATE, 2'd3, 22'h03FF00, 10'd0,    10'h000}, 1'b0, FAULTED},
      '{'{MODE_TRANSLATE, 2'd0, 22'h0005AB, 10'd0,    10'h000}, 1'b0, FAULTED},
      '{'{MODE_TRANSLATE, 2'd1, 22'h000100, 10'd0,    10'h000}, 1'b0, FAULTED},
      '{'{MODE_TRANSLATE, 2'd2, 22'h0009FF, 10'd0,    10'h000}, 1'b0, FAULTED}
    };

    // Hold every input at a known value from time zero
    rst_n              = 1'b0;
    start              = 1'b0;
    in_mode            = MODE_TRANSLATE;
    in_process_id      = '0;
    in_virtual_address = '0;
    in_page_number     = '0;
    in_frame_number    = '0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_POLICY;
    cfg_data           = '0;
    idle_enable        = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Registers land even during the page table clearing pass
    write_register(CFG_POLICY, 4'd0);
    write_register(CFG_OFFSET, OFFSET_BITS_RST);

    foreach (directed_rows[i]) begin
      maybe_idle();
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases, each under its own register setting; the block is drained
    // before each write, and the final phase runs flat out with no idling.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_register(CFG_POLICY, {3'($urandom_range(0, 7)), phase_policy[p]});
      write_register(CFG_OFFSET, phase_offset[p]);
      idle_enable = (p != PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        maybe_idle();
        send_request(random_request(), 1'b0, FAULTED);
      end
    end
    drain();

    $display("Checked %0d items: %0d hits, %0d fills, %0d faults, %0d map/unmap",
             items_accepted, status_seen[STAT_HIT], status_seen[STAT_FILL],
             status_seen[STAT_FAULT], status_seen[STAT_DONE]);
    $display("Covered FIFO and LRU replacement with offset widths from 0 to 15");
    if (failures == 0) begin
      $display("tagged_tlb_page_translation_unit test passed");
    end else begin
      $display("tagged_tlb_page_translation_unit test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/ttlb_pkg.sv
hdl/ttlb_ram.sv
hdl/tagged_tlb_page_translation_unit.sv
test/tagged_tlb_page_translation_unit_test.sv
